[rtl/ctlex_pkg.sv]
package ctlex_pkg;

  // Result status codes
  localparam logic [1:0] STAT_TOKEN   = 2'd0;
  localparam logic [1:0] STAT_FAULT   = 2'd1;
  localparam logic [1:0] STAT_STR_END = 2'd2;
  localparam logic [1:0] STAT_END     = 2'd3;

  // Token kinds
  localparam logic [3:0] KIND_LBRACE = 4'd0;
  localparam logic [3:0] KIND_RBRACE = 4'd1;
  localparam logic [3:0] KIND_LBRACK = 4'd2;
  localparam logic [3:0] KIND_RBRACK = 4'd3;
  localparam logic [3:0] KIND_EQUAL  = 4'd4;
  localparam logic [3:0] KIND_COMMA  = 4'd5;
  localparam logic [3:0] KIND_SEMI   = 4'd6;
  localparam logic [3:0] KIND_COLON  = 4'd7;
  localparam logic [3:0] KIND_DOLLAR = 4'd8;
  localparam logic [3:0] KIND_WORD   = 4'd9;
  localparam logic [3:0] KIND_NONE   = 4'd0;

  // Characters
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;

  // Result queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  token_kind;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [15:0] line_number;
  } ctlex_result_t;

  // Up to two results caused by one input byte
  typedef struct packed {
    logic          two;
    ctlex_result_t r0;
    ctlex_result_t r1;
  } ctlex_job_t;

  function automatic ctlex_result_t mk_result(input logic [1:0] status,
                                              input logic [3:0] kind,
                                              input logic [15:0] start,
                                              input logic [15:0] len,
                                              input logic [15:0] line);
    ctlex_result_t r;
    r.status       = status;
    r.token_kind   = kind;
    r.start_offset = start;
    r.token_length = len;
    r.line_number  = line;
    return r;
  endfunction

endpackage

[rtl/ctlex_in_if.sv]
interface ctlex_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_text;

  modport source(output valid, output char_byte, output end_of_text, input ready);
  modport sink(input valid, input char_byte, input end_of_text, output ready);
endinterface

[rtl/ctlex_out_if.sv]
interface ctlex_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  token_kind;
  logic [15:0] start_offset;
  logic [15:0] token_length;
  logic [15:0] line_number;
  logic        last_of_run;

  modport source(output valid, output status, output token_kind, output start_offset,
                 output token_length, output line_number, output last_of_run,
                 input ready);
  modport sink(input valid, input status, input token_kind, input start_offset,
               input token_length, input line_number, input last_of_run,
               output ready);
endinterface

[rtl/config_text_lexer_core.sv]
// Config text lexer core.
// char_in (sink): one text byte per request in char_byte; end_of_text = 1
//   closes the text (char_byte ignored), flushes an open identifier or ends an
//   open string, and returns the lexer to its reset state after giving an end marker.
// token_out (source): one result per request: status, token_kind,
//   start_offset, token_length, line_number; last_of_run marks the final
//   result caused by one input byte (at most two per byte).
// Results reach token_out from the head of the queue. Throughput: one byte
//   per cycle while the queue is not full. The lexer front decides all
//   results of a byte in the cycle it takes it and writes them as one
//   entry into a 4-entry queue; the back drains one result per cycle while
//   token_out is ready, so a two-result entry holds the queue head until both are taken.
// Bytes that cause no result (whitespace, comments, identifier bodies,
//   string text, bytes after a fault) never enter the queue.
// Stall: when token_out is not ready the queue fills; char_in.ready drops
//   only when the queue is full. Results are never dropped or reordered.
// Reset (rst, synchronous): queue emptied, lexer idle at offset 0, line 1.
module config_text_lexer_core
  import ctlex_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  ctlex_in_if.sink    char_in,
  ctlex_out_if.source token_out
);

  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  ctlex_job_t q_in;
  ctlex_job_t q_head;

  // classify bytes and run the lexer state
  ctlex_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .char_in  (char_in),
    .q_full   (q_full),
    .push     (q_push),
    .push_job (q_in)
  );

  ctlex_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_in),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // serialize one or two results per queue entry
  ctlex_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .empty     (q_empty),
    .pop       (q_pop),
    .token_out (token_out)
  );

  // non-token results carry no kind and no length
  a_fault_fields: assert property (@(posedge clk) disable iff (rst)
    (token_out.valid && token_out.status != STAT_TOKEN) |->
      (token_out.token_length == 16'd0 && token_out.token_kind == KIND_NONE))
    else $error("non-token result with kind or length");

  // end marker always closes its run
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (token_out.valid && token_out.status == STAT_END) |-> token_out.last_of_run)
    else $error("end marker not last of run");

  // end inside string is always followed by the end marker
  a_str_end: assert property (@(posedge clk) disable iff (rst)
    (token_out.valid && token_out.status == STAT_STR_END) |-> !token_out.last_of_run)
    else $error("end inside string marked last");

  // queue occupancy flags are consistent
  a_queue_flags: assert property (@(posedge clk) disable iff (rst)
    !(q_full && q_empty) && (char_in.ready == !q_full))
    else $error("queue flags inconsistent");

endmodule

[rtl/ctlex_front.sv]
module ctlex_front
  import ctlex_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  ctlex_in_if.sink   char_in,
  input  logic       q_full,
  output logic       push,
  output ctlex_job_t push_job
);

  localparam int unsigned P = POSITION_BITS;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_IDENT,
    MODE_STRING,
    MODE_FAULT
  } mode_t;

  mode_t       mode, mode_next;
  logic [P-1:0] pos, pos_next, tok_start, tok_start_next;
  logic [15:0]  line, line_next, tok_line, tok_line_next;

  logic [P-1:0] pos_inc, open_len;
  logic [15:0]  line_inc;
  logic         fire;
  logic [7:0]   c;
  logic         is_ident, is_punct;
  logic [3:0]   punct_kind;
  logic         flush, idle_go, idle_has;
  ctlex_result_t tok_res, idle_res, r0, r1;
  logic [1:0]   nres;

  function automatic logic [15:0] to16(input logic [P-1:0] v);
    logic [P+15:0] e;
    e = (P+16)'(v);
    return e[15:0];
  endfunction

  assign char_in.ready = !q_full;
  assign fire = char_in.valid && char_in.ready;
  assign c    = char_in.char_byte;

  assign pos_inc  = (&pos) ? pos : pos + P'(1);
  assign line_inc = (&line) ? line : line + 16'd1;
  assign open_len = (pos >= tok_start) ? pos - tok_start : '0;

  assign is_ident = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
                    (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER || c == CH_DOT ||
                    c == CH_SLASH;

  always_comb begin
    is_punct   = 1'b1;
    punct_kind = KIND_NONE;
    case (c)
      CH_LBRACE: punct_kind = KIND_LBRACE;
      CH_RBRACE: punct_kind = KIND_RBRACE;
      CH_LBRACK: punct_kind = KIND_LBRACK;
      CH_RBRACK: punct_kind = KIND_RBRACK;
      CH_EQUAL:  punct_kind = KIND_EQUAL;
      CH_COMMA:  punct_kind = KIND_COMMA;
      CH_SEMI:   punct_kind = KIND_SEMI;
      CH_COLON:  punct_kind = KIND_COLON;
      CH_DOLLAR: punct_kind = KIND_DOLLAR;
      default:   is_punct   = 1'b0;
    endcase
  end

  assign tok_res = mk_result(STAT_TOKEN, KIND_WORD, to16(tok_start), to16(open_len), tok_line);

  always_comb begin
    mode_next      = mode;
    pos_next       = pos;
    line_next      = line;
    tok_start_next = tok_start;
    tok_line_next  = tok_line;
    r0             = '0;
    r1             = '0;
    nres           = 2'd0;
    flush          = 1'b0;
    idle_go        = 1'b0;
    idle_has       = 1'b0;
    idle_res       = '0;

    if (char_in.end_of_text) begin
      // identifier flush or end-inside-string result, end marker, then back to reset values
      if (mode == MODE_IDENT) begin
        r0   = tok_res;
        r1   = mk_result(STAT_END, KIND_NONE, to16(pos), 16'd0, line);
        nres = 2'd2;
      end else if (mode == MODE_STRING) begin
        r0   = mk_result(STAT_STR_END, KIND_NONE, to16(pos), 16'd0, line);
        r1   = mk_result(STAT_END, KIND_NONE, to16(pos), 16'd0, line);
        nres = 2'd2;
      end else begin
        r0   = mk_result(STAT_END, KIND_NONE, to16(pos), 16'd0, line);
        nres = 2'd1;
      end
      mode_next      = MODE_IDLE;
      pos_next       = '0;
      line_next      = 16'd1;
      tok_start_next = '0;
      tok_line_next  = 16'd1;
    end else begin
      case (mode)
        MODE_FAULT: begin
        end
        MODE_COMMENT: begin
          if (c == CH_NL) begin
            line_next = line_inc;
            mode_next = MODE_IDLE;
          end
          pos_next = pos_inc;
        end
        MODE_STRING: begin
          if (c == CH_QUOTE) begin
            r0        = tok_res;
            nres      = 2'd1;
            mode_next = MODE_IDLE;
          end else if (c == CH_NL) begin
            line_next = line_inc;
          end
          pos_next = pos_inc;
        end
        MODE_IDENT: begin
          if (is_ident) begin
            pos_next = pos_inc;
          end else begin
            flush     = 1'b1;
            idle_go   = 1'b1;
            mode_next = MODE_IDLE;
          end
        end
        MODE_IDLE: begin
          idle_go = 1'b1;
        end
        default: begin
          idle_go   = 1'b1;
          mode_next = MODE_IDLE;
        end
      endcase

      if (idle_go) begin
        if (c == CH_SPACE || c == CH_TAB) begin
        end else if (c == CH_NL) begin
          line_next = line_inc;
        end else if (c == CH_HASH) begin
          mode_next = MODE_COMMENT;
        end else if (is_punct) begin
          idle_has = 1'b1;
          idle_res = mk_result(STAT_TOKEN, punct_kind, to16(pos), 16'd1, line);
        end else if (is_ident) begin
          mode_next      = MODE_IDENT;
          tok_start_next = pos;
          tok_line_next  = line;
        end else if (c == CH_QUOTE) begin
          mode_next      = MODE_STRING;
          tok_start_next = pos_inc;
          tok_line_next  = line;
        end else begin
          idle_has  = 1'b1;
          idle_res  = mk_result(STAT_FAULT, KIND_NONE, to16(pos), 16'd0, line);
          mode_next = MODE_FAULT;
        end
        pos_next = pos_inc;

        if (flush) begin
          r0   = tok_res;
          r1   = idle_res;
          nres = idle_has ? 2'd2 : 2'd1;
        end else if (idle_has) begin
          r0   = idle_res;
          nres = 2'd1;
        end
      end
    end
  end

  assign push          = fire && (nres != 2'd0);
  assign push_job.two  = (nres == 2'd2);
  assign push_job.r0   = r0;
  assign push_job.r1   = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      pos       <= '0;
      line      <= 16'd1;
      tok_start <= '0;
      tok_line  <= 16'd1;
    end else if (fire) begin
      mode      <= mode_next;
      pos       <= pos_next;
      line      <= line_next;
      tok_start <= tok_start_next;
      tok_line  <= tok_line_next;
    end
  end

endmodule

[rtl/ctlex_queue.sv]
module ctlex_queue
  import ctlex_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  ctlex_job_t push_job,
  input  logic       pop,
  output ctlex_job_t head,
  output logic       full,
  output logic       empty
);

  ctlex_job_t          mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_CW-1:0] count;
  logic                do_push, do_pop;

  assign full    = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QUEUE_AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QUEUE_CW'(1);
        2'b01:   count <= count - QUEUE_CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/ctlex_back.sv]
module ctlex_back
  import ctlex_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ctlex_job_t  head,
  input  logic        empty,
  output logic        pop,
  ctlex_out_if.source token_out
);

  // set while the second result of the head job is on the port
  logic          sel;
  logic          last;
  logic          fire;
  ctlex_result_t cur;

  assign cur  = sel ? head.r1 : head.r0;
  assign last = sel || !head.two;
  assign fire = token_out.valid && token_out.ready;
  assign pop  = fire && last;

  assign token_out.valid        = !empty;
  assign token_out.status       = cur.status;
  assign token_out.token_kind   = cur.token_kind;
  assign token_out.start_offset = cur.start_offset;
  assign token_out.token_length = cur.token_length;
  assign token_out.line_number  = cur.line_number;
  assign token_out.last_of_run  = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
    end else if (fire) begin
      sel <= !last;
    end
  end

endmodule
